// ===== src/mersenne_twister_state_engine_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers for the state engine checks.
// ----------------------------------------------------------------------------
`ifndef MERSENNE_TWISTER_STATE_ENGINE_DEFINES_SVH
`define MERSENNE_TWISTER_STATE_ENGINE_DEFINES_SVH

// same-cycle implication
`define MTSE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MTSE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/mtse_pkg.sv =====
// ----------------------------------------------------------------------------
// MT state engine package
// Widths, recurrence constants and sequencer states.
// ----------------------------------------------------------------------------
package mtse_pkg;

	localparam int WORD_W       = 32;
	localparam int POS_W        = 10;
	localparam int STATE_WORDS  = 624;
	localparam int TWIST_OFFSET = 397;

	localparam logic [WORD_W-1:0] TW_MATRIX  = 32'h9908_b0df;
	localparam logic [WORD_W-1:0] SEED_MULT  = 32'd1812433253;
	localparam logic [WORD_W-1:0] SEED_RESET = 32'd5489;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED,
		ST_TW_PRE,
		ST_TWIST,
		ST_READ,
		ST_RESP
	} mtse_state_t;

endpackage

// ===== src/mtse_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one request bit.
// ----------------------------------------------------------------------------
interface mtse_req_if;
	logic valid;
	logic ready;
	logic request;

	modport source (output valid, output request, input ready);
	modport sink (input valid, input request, output ready);
endinterface

// ===== src/mtse_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying a state word and its position.
// ----------------------------------------------------------------------------
interface mtse_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [mtse_pkg::WORD_W-1:0]      state_word;
	logic [mtse_pkg::POS_W-1:0]       word_position;

	modport source (output valid, output state_word, output word_position, input ready);
	modport sink (input valid, input state_word, input word_position, output ready);
endinterface

// ===== src/mersenne_twister_state_engine.sv =====
// ----------------------------------------------------------------------------
// MT19937 state engine
// Hands out untempered state words; seeds and twists a 624-word store.
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  --------+-----+--------------+------------------------------------
//  req     | in  | valid/ready  | request (1)
//  rsp     | out | valid/ready  | state_word (32), word_position (10)
//  seed    | in  | seed_we      | seed_data (32)
//
//  A request with words left passes accept, store read and response load in turn.
//  Exhausting the store adds a twist: a priming read, then one word per
//  cycle through the two read ports of the store.
//  Seeding adds a pass over the store, one multiply-add per cycle, then a twist.
//  No clearing pass after reset; the first request seeds from 5489.
//  A waiting response stalls the next response load and with it new requests.
// ----------------------------------------------------------------------------
`include "mersenne_twister_state_engine_defines.svh"

module mersenne_twister_state_engine #(
	parameter int STATE_WORDS  = mtse_pkg::STATE_WORDS,
	parameter int TWIST_OFFSET = mtse_pkg::TWIST_OFFSET
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        seed_we,
	input  logic [mtse_pkg::WORD_W-1:0] seed_data,
	mtse_req_if.sink                    req,
	mtse_rsp_if.source                  rsp
);

	localparam int PosW  = mtse_pkg::POS_W;
	localparam int WordW = mtse_pkg::WORD_W;
	localparam logic [PosW-1:0] LastIdx  = PosW'(STATE_WORDS - 1);
	localparam logic [PosW-1:0] WordsCnt = PosW'(STATE_WORDS);
	localparam logic [PosW-1:0] Offset   = PosW'(TWIST_OFFSET);
	localparam logic [PosW-1:0] Wrap     = PosW'(STATE_WORDS - TWIST_OFFSET);

	mtse_pkg::mtse_state_t state_q, state_d;

	logic [PosW-1:0]  idx_q, idx_d;
	logic [PosW-1:0]  pos_q, pos_d;
	logic             seeded_q;
	logic             seeded_set;
	logic [WordW-1:0] seed_q;
	logic [WordW-1:0] x_q;

	logic [WordW-1:0] state_mem_q [STATE_WORDS];
	logic [WordW-1:0] rd_a_q, rd_b_q;
	logic [PosW-1:0]  rd_addr_a, rd_addr_b;
	logic             mem_we;
	logic [PosW-1:0]  wr_addr;
	logic [WordW-1:0] wr_data;

	logic             seed_wr, tw_issue, pre_issue, out_load;
	logic             tw_s1, pre_s1;
	logic [PosW-1:0]  tw_idx_s1;
	logic [WordW-1:0] cur_q;

	logic [PosW-1:0]  nxt_idx, far_idx;
	logic [WordW-1:0] seed_prod, seed_next;
	logic [WordW-1:0] mix, tw_val;

	logic             out_valid_q;
	logic [WordW-1:0] out_word_q;
	logic [PosW-1:0]  out_pos_q;

	assign nxt_idx = (idx_q == LastIdx) ? '0 : idx_q + PosW'(1);
	assign far_idx = (idx_q >= Wrap) ? idx_q - Wrap : idx_q + Offset;

	// Knuth recurrence: one multiply-add per cycle
	assign seed_prod = WordW'(mtse_pkg::SEED_MULT * (x_q ^ (x_q >> 30)));
	assign seed_next = (idx_q == '0) ? seed_q : seed_prod + WordW'(idx_q);

	// twist of word tw_idx_s1
	assign mix    = {cur_q[WordW-1], rd_a_q[WordW-2:0]};
	assign tw_val = rd_b_q ^ (mix >> 1) ^ (rd_a_q[0] ? mtse_pkg::TW_MATRIX : '0);

	assign mem_we  = seed_wr || tw_s1;
	assign wr_addr = seed_wr ? idx_q : tw_idx_s1;
	assign wr_data = seed_wr ? seed_next : tw_val;

	assign req.ready         = (state_q == mtse_pkg::ST_IDLE);
	assign rsp.valid         = out_valid_q;
	assign rsp.state_word    = out_word_q;
	assign rsp.word_position = out_pos_q;

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		pos_d      = pos_q;
		seeded_set = 1'b0;
		rd_addr_a  = pos_q;
		rd_addr_b  = far_idx;
		seed_wr    = 1'b0;
		tw_issue   = 1'b0;
		pre_issue  = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			mtse_pkg::ST_IDLE: begin
				if (req.valid && req.request) begin
					priority if (!seeded_q) begin
						idx_d   = '0;
						state_d = mtse_pkg::ST_SEED;
					end else if (pos_q >= WordsCnt) begin
						state_d = mtse_pkg::ST_TW_PRE;
					end else begin
						state_d = mtse_pkg::ST_READ;
					end
				end
			end
			mtse_pkg::ST_SEED: begin
				seed_wr = 1'b1;
				if (idx_q == LastIdx) begin
					seeded_set = 1'b1;
					pos_d      = WordsCnt;
					state_d    = mtse_pkg::ST_TW_PRE;
				end else begin
					idx_d = idx_q + PosW'(1);
				end
			end
			mtse_pkg::ST_TW_PRE: begin
				rd_addr_a = '0;
				pre_issue = 1'b1;
				idx_d     = '0;
				state_d   = mtse_pkg::ST_TWIST;
			end
			mtse_pkg::ST_TWIST: begin
				rd_addr_a = nxt_idx;
				tw_issue  = 1'b1;
				if (idx_q == LastIdx) begin
					pos_d   = '0;
					state_d = mtse_pkg::ST_READ;
				end else begin
					idx_d = idx_q + PosW'(1);
				end
			end
			mtse_pkg::ST_READ: begin
				state_d = mtse_pkg::ST_RESP;
			end
			mtse_pkg::ST_RESP: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					pos_d    = pos_q + PosW'(1);
					state_d  = mtse_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mtse_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mtse_pkg::ST_IDLE;
			idx_q       <= '0;
			pos_q       <= WordsCnt;
			seeded_q    <= 1'b0;
			seed_q      <= mtse_pkg::SEED_RESET;
			tw_s1       <= 1'b0;
			pre_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			pos_q   <= pos_d;
			tw_s1   <= tw_issue;
			pre_s1  <= pre_issue;
			if (seed_we) begin
				seed_q   <= seed_data;
				seeded_q <= 1'b0;
			end else if (seeded_set) begin
				seeded_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tw_idx_s1 <= idx_q;
		if (seed_wr) begin
			x_q <= seed_next;
		end
		if (tw_s1 || pre_s1) begin
			cur_q <= rd_a_q;
		end
		if (out_load) begin
			out_word_q <= rd_a_q;
			out_pos_q  <= pos_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			state_mem_q[wr_addr] <= wr_data;
		end
		rd_a_q <= state_mem_q[rd_addr_a];
		rd_b_q <= state_mem_q[rd_addr_b];
	end

	`MTSE_ASSERT_IMP(a_pos_range, clk, arst_n, rsp.valid,
		rsp.word_position < WordsCnt, "word position out of range")
	`MTSE_ASSERT_IMP(a_wr_excl, clk, arst_n, tw_s1, !seed_wr,
		"seed and twist write collide")
	`MTSE_ASSERT_NXT(a_seed_to_twist, clk, arst_n,
		(state_q == mtse_pkg::ST_SEED) && (idx_q == LastIdx),
		state_q == mtse_pkg::ST_TW_PRE, "seeding not followed by twist")
	`MTSE_ASSERT_IMP(a_resp_pos, clk, arst_n, state_q == mtse_pkg::ST_RESP,
		pos_q < WordsCnt, "response from exhausted store")
	`MTSE_ASSERT_IMP(a_wr_addr, clk, arst_n, mem_we, wr_addr < WordsCnt,
		"store write out of range")

endmodule

// ===== tb/mtse_word_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MT state engine word checker
// Watches the seed port and both channels, keeps its own copy of the
// 624-word store, and checks every response's word and position.
// ----------------------------------------------------------------------------
module mtse_word_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        seed_we,
	input  logic [mtse_pkg::WORD_W-1:0] seed_data,
	mtse_req_if                         req,
	mtse_rsp_if                         rsp,
	output int                          mismatches,
	output int                          words_owed
);

	typedef struct packed {
		logic [mtse_pkg::WORD_W-1:0] word;
		logic [mtse_pkg::POS_W-1:0]  pos;
	} mt_draw_t;

	logic [mtse_pkg::WORD_W-1:0] mt_store [mtse_pkg::STATE_WORDS];
	int unsigned                 mt_pos;
	logic                        mt_seeded;
	logic [mtse_pkg::WORD_W-1:0] mt_seed;
	mt_draw_t                    draws_due [$];

	always @(posedge clk) begin : track
		logic [mtse_pkg::WORD_W-1:0] prev;
		logic [mtse_pkg::WORD_W-1:0] mix;
		logic [mtse_pkg::WORD_W-1:0] val;
		int                          nxt;
		int                          far;
		mt_draw_t                    got;
		mt_draw_t                    want;
		mt_draw_t                    due;
		if (!arst_n) begin
			mt_pos     = mtse_pkg::STATE_WORDS;
			mt_seeded  = 1'b0;
			mt_seed    = mtse_pkg::SEED_RESET;
			mismatches = 0;
			draws_due.delete();
		end else begin
			if (seed_we) begin
				mt_seed   = seed_data;
				mt_seeded = 1'b0;
			end
			if (req.valid && req.ready && req.request) begin
				if (!mt_seeded) begin
					mt_store[0] = mt_seed;
					for (int i = 1; i < mtse_pkg::STATE_WORDS; i++) begin
						prev        = mt_store[i-1];
						mt_store[i] = mtse_pkg::SEED_MULT * (prev ^ (prev >> 30))
							+ mtse_pkg::WORD_W'(i);
					end
					mt_seeded = 1'b1;
					mt_pos    = mtse_pkg::STATE_WORDS;
				end
				if (mt_pos >= mtse_pkg::STATE_WORDS) begin
					for (int i = 0; i < mtse_pkg::STATE_WORDS; i++) begin
						nxt = (i + 1) % mtse_pkg::STATE_WORDS;
						far = (i + mtse_pkg::TWIST_OFFSET) % mtse_pkg::STATE_WORDS;
						mix = {mt_store[i][mtse_pkg::WORD_W-1],
							mt_store[nxt][mtse_pkg::WORD_W-2:0]};
						val = mt_store[far] ^ (mix >> 1);
						if (mt_store[nxt][0])
							val = val ^ mtse_pkg::TW_MATRIX;
						mt_store[i] = val;
					end
					mt_pos = 0;
				end
				due.word = mt_store[mt_pos];
				due.pos  = mtse_pkg::POS_W'(mt_pos);
				draws_due.push_back(due);
				mt_pos++;
			end
			if (rsp.valid && rsp.ready) begin
				got.word = rsp.state_word;
				got.pos  = rsp.word_position;
				if (draws_due.size() == 0) begin
					mismatches++;
					$error("state_word: expected none, got %h at position %0d",
						got.word, got.pos);
				end else begin
					want = draws_due.pop_front();
					if (got.word !== want.word) begin
						mismatches++;
						$error("state_word: expected %h, got %h", want.word, got.word);
					end
					if (got.pos !== want.pos) begin
						mismatches++;
						$error("word_position: expected %0d, got %0d", want.pos, got.pos);
					end
				end
			end
		end
		words_owed = draws_due.size();
	end

endmodule

// ===== tb/mersenne_twister_state_engine_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MT state engine testbench
// Drives requests and seed writes into the state engine under varying
// backpressure, including a long response stall, and reports the verdict
// from the word checker's mismatch count.
// ----------------------------------------------------------------------------
module mersenne_twister_state_engine_test;

	localparam int RANDOM_REQUESTS = 160;
	localparam int TAIL_REQUESTS   = 40;
	localparam int SETTLE_CYCLES   = 8;
	localparam int QUIET_LIMIT     = 6000;
	localparam int HOLD_AT         = 300;
	localparam int HOLD_CYCLES     = 400;

	logic                        clk;
	logic                        arst_n;
	logic                        seed_we;
	logic [mtse_pkg::WORD_W-1:0] seed_data;
	int                          mismatches;
	int                          words_owed;
	int                          send_idle_pct;
	int                          rcv_idle_pct;
	int                          quiet_cycles = 0;

	mtse_req_if req_ch();
	mtse_rsp_if rsp_ch();

	mersenne_twister_state_engine u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed_we   (seed_we),
		.seed_data (seed_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	mtse_word_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed_we    (seed_we),
		.seed_data  (seed_data),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.mismatches (mismatches),
		.words_owed (words_owed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : receiver
		int taken;
		bit held;
		taken = 0;
		held  = 1'b0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				taken++;
			// hold off long enough for the engine to back up into the request side
			if (taken >= HOLD_AT && !held) begin
				held = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	task automatic offer_request(input logic want);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.request <= want;
		do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
	endtask

	task automatic drain_and_settle();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (words_owed != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_seed(input logic [mtse_pkg::WORD_W-1:0] value);
		seed_we   <= 1'b1;
		seed_data <= value;
		@(posedge clk);
		seed_we   <= 1'b0;
	endtask

	initial begin : stimulus
		int   n;
		int   goal;
		logic want;
		arst_n         <= 1'b0;
		seed_we        <= 1'b0;
		seed_data      <= '0;
		req_ch.valid   <= 1'b0;
		req_ch.request <= 1'b0;
		send_idle_pct = 29;
		rcv_idle_pct  = 73;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset seed; an empty request first must not trigger seeding output
		offer_request(1'b0);
		offer_request(1'b1);
		offer_request(1'b1);
		offer_request(1'b0);
		offer_request(1'b1);
		offer_request(1'b1);
		drain_and_settle();

		// reseed partway through the store
		write_seed('0);
		offer_request(1'b1);
		offer_request(1'b0);
		offer_request(1'b1);
		offer_request(1'b1);
		drain_and_settle();

		write_seed('1);
		offer_request(1'b1);
		offer_request(1'b1);
		offer_request(1'b1);
		drain_and_settle();

		// back-to-back writes: the later seed wins
		seed_we   <= 1'b1;
		seed_data <= $urandom();
		@(posedge clk);
		seed_data <= mtse_pkg::SEED_RESET;
		@(posedge clk);
		seed_we   <= 1'b0;
		offer_request(1'b1);
		offer_request(1'b1);
		drain_and_settle();

		write_seed($urandom());
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 73 : 0;
			rcv_idle_pct  = (phase == 0) ? 73 : (phase == 1) ? 29 : 0;
			goal          = (phase == 3) ? TAIL_REQUESTS : RANDOM_REQUESTS;
			if (phase == 3) begin
				drain_and_settle();
				write_seed($urandom());
			end
			n = 0;
			while (n < goal) begin
				want = ($urandom_range(7) != 0);
				offer_request(want);
				if (want)
					n++;
			end
		end
		drain_and_settle();

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== mersenne_twister_state_engine.f =====
+incdir+src
src/mtse_pkg.sv
src/mtse_req_if.sv
src/mtse_rsp_if.sv
src/mersenne_twister_state_engine.sv
tb/mtse_word_checker.sv
tb/mersenne_twister_state_engine_test.sv
